/* rtl/psu_pkg.sv */
// Shared types, codes and constants of the per-source sequence unwrapper.
package psu_pkg;

    localparam int NUM_SOURCES_DEF = 64;
    localparam int SEQ_BITS_DEF    = 11;
    localparam int ABS_BITS_DEF    = 46;

    localparam int BLEN_W   = 12;
    localparam int CODEC_W  = 8;
    localparam int SRC_W    = 16;
    localparam int RAW_W    = 11;
    localparam int SLOT_W   = 6;
    localparam int TS_W     = 58;
    localparam int CFG_IDX_W = 8;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OPUS_BLEN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PCM_BLEN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNTH_BLEN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OTHER_BLEN = 8'd3;

    // Codec ids.
    localparam logic [CODEC_W-1:0] CODEC_OPUS  = 8'd0;
    localparam logic [CODEC_W-1:0] CODEC_PCM   = 8'd1;
    localparam logic [CODEC_W-1:0] CODEC_SYNTH = 8'd2;

    localparam logic [BLEN_W-1:0] OPUS_BLEN_RST  = 12'd960;
    localparam logic [BLEN_W-1:0] PCM_BLEN_RST   = 12'd120;
    localparam logic [BLEN_W-1:0] SYNTH_BLEN_RST = 12'd960;
    localparam logic [BLEN_W-1:0] OTHER_BLEN_RST = 12'd960;

    // Per-slot fields that travel between a cell and the control.
    typedef struct packed {
        logic               opened;
        logic [CODEC_W-1:0] codec;
        logic [BLEN_W-1:0]  blen;
    } t_slot_meta;

endpackage

/* rtl/psu_cell.sv */
// One slot of the source table: storage, match compare and free-slot chain link.
module psu_cell #(
    parameter int ABS_BITS = psu_pkg::ABS_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [psu_pkg::SRC_W-1:0] i_query_src,
    input  logic                     i_free_seen,
    output logic                     o_free_seen,
    output logic                     o_hit,
    output logic                     o_grant,
    output psu_pkg::t_slot_meta      o_meta,
    output logic [ABS_BITS-1:0]      o_high,
    input  logic                     i_we,
    input  logic [psu_pkg::SRC_W-1:0] i_wr_src,
    input  psu_pkg::t_slot_meta      i_wr_meta,
    input  logic [ABS_BITS-1:0]      i_wr_high
);
    import psu_pkg::*;

    logic               r_used;
    logic               r_opened;
    logic [SRC_W-1:0]   r_source;
    logic [CODEC_W-1:0] r_codec;
    logic [BLEN_W-1:0]  r_blen;
    logic [ABS_BITS-1:0] r_high;

    // A free slot passes "a lower free slot exists" on to its upper neighbor.
    assign o_free_seen = i_free_seen | ~r_used;
    assign o_grant     = ~r_used & ~i_free_seen;
    assign o_hit       = r_used & (r_source == i_query_src);

    assign o_meta.opened = r_opened;
    assign o_meta.codec  = r_codec;
    assign o_meta.blen   = r_blen;
    assign o_high        = r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= 1'b0;
            r_opened <= 1'b0;
        end else if (i_we) begin
            r_used   <= 1'b1;
            r_opened <= i_wr_meta.opened;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_source <= i_wr_src;
            r_codec  <= i_wr_meta.codec;
            r_blen   <= i_wr_meta.blen;
            r_high   <= i_wr_high;
        end
    end

endmodule

/* rtl/per_source_sequence_unwrapper.sv */
// Top level of the per-source sequence unwrapper: control sequencer and row of slot cells.
//
// One input beat describes a control frame. The block looks the source up in a row of
// NUM_SOURCES slot cells, each of which compares the source against its own entry and
// passes a "free slot below" flag to its upper neighbor so that the lowest free slot is
// granted to a new source. The sequencer then reads the chosen slot, unwraps the rolling
// packet id against the slot's highest absolute id, writes the slot back and multiplies the
// absolute id by the slot's block length to give the timestamp. One item is in flight at a
// time: a beat is accepted in the idle state and passes through the lookup, read, unwrap
// and multiply steps of the sequencer (the multiply is skipped when the frame completes no
// packet, and a full table goes from the lookup straight to the output step); the output
// step loads the result once the output register is free, and the next beat is taken after
// that. The result then waits in the output register while the next beat is accepted.
// Configuration writes are taken at any time and should only be made while the block is
// idle. There is no clearing pass after reset.
module per_source_sequence_unwrapper #(
    parameter int NUM_SOURCES = psu_pkg::NUM_SOURCES_DEF,
    parameter int SEQ_BITS    = psu_pkg::SEQ_BITS_DEF,
    parameter int ABS_BITS    = psu_pkg::ABS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream. tdata from bit 0: source_id[15:0], packet_done[16], seq_raw[27:17],
    // codec_kind[35:28], zero padding[39:36].
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [psu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Result stream. tdata from bit 0: accepted[0], slot_index[6:1], emitted[7],
    // first_packet[8], timestamp[66:9], duration[78:67], stored_codec[86:79],
    // zero padding[87].
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [psu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psu_pkg::BLEN_W-1:0]      i_cfg_data
);
    import psu_pkg::*;

    localparam int CW    = $clog2(NUM_SOURCES);
    localparam int PW    = ABS_BITS + BLEN_W;
    localparam int AW1   = ABS_BITS + 1;
    localparam logic [SEQ_BITS:0]    SEQ_HALF = (SEQ_BITS + 1)'(1) << (SEQ_BITS - 1);
    localparam logic [SEQ_BITS:0]    SEQ_MOD  = (SEQ_BITS + 1)'(1) << SEQ_BITS;
    localparam logic [ABS_BITS-1:0]  ABS_MAX  = {ABS_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_READ, S_CALC, S_MUL, S_OUT
    } t_state;

    // Configuration registers.
    logic [BLEN_W-1:0] r_opus_blen, r_pcm_blen, r_synth_blen, r_other_blen;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opus_blen  <= OPUS_BLEN_RST;
            r_pcm_blen   <= PCM_BLEN_RST;
            r_synth_blen <= SYNTH_BLEN_RST;
            r_other_blen <= OTHER_BLEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OPUS_BLEN:  r_opus_blen  <= i_cfg_data;
                REG_PCM_BLEN:   r_pcm_blen   <= i_cfg_data;
                REG_SYNTH_BLEN: r_synth_blen <= i_cfg_data;
                REG_OTHER_BLEN: r_other_blen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and item registers.
    t_state                r_state;
    logic [SRC_W-1:0]      r_src;
    logic                  r_done;
    logic [SEQ_BITS-1:0]   r_raw;
    logic [CODEC_W-1:0]    r_codec;
    logic [NUM_SOURCES-1:0] r_sel;
    logic                  r_hit;
    logic                  r_full;
    t_slot_meta            r_old_meta;
    logic [ABS_BITS-1:0]   r_old_high;
    logic [BLEN_W-1:0]     r_new_blen;
    logic                  r_first;
    logic [ABS_BITS-1:0]   r_abs;
    logic [BLEN_W-1:0]     r_dur;
    logic [CODEC_W-1:0]    r_scodec;
    logic [PW-1:0]         r_prod;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Raw id taken to SEQ_BITS bits.
    logic [SEQ_BITS-1:0] n_raw;
    always_comb begin
        for (int b = 0; b < SEQ_BITS; b++) begin
            n_raw[b] = (b < RAW_W) ? s_axis_tdata[17 + b] : 1'b0;
        end
    end

    // Row of cells.
    logic [NUM_SOURCES:0]   cell_free_seen;
    logic [NUM_SOURCES-1:0] cell_hit;
    logic [NUM_SOURCES-1:0] cell_grant;
    t_slot_meta             cell_meta [NUM_SOURCES];
    logic [ABS_BITS-1:0]    cell_high [NUM_SOURCES];
    logic                   wr_en;
    t_slot_meta             wr_meta;
    logic [ABS_BITS-1:0]    wr_high;

    assign cell_free_seen[0] = 1'b0;

    for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_cell
        psu_cell #(
            .ABS_BITS(ABS_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_query_src(r_src),
            .i_free_seen(cell_free_seen[g]),
            .o_free_seen(cell_free_seen[g + 1]),
            .o_hit      (cell_hit[g]),
            .o_grant    (cell_grant[g]),
            .o_meta     (cell_meta[g]),
            .o_high     (cell_high[g]),
            .i_we       (wr_en & r_sel[g]),
            .i_wr_src   (r_src),
            .i_wr_meta  (wr_meta),
            .i_wr_high  (wr_high)
        );
    end

    // Read-out of the selected slot, and its index.
    t_slot_meta          rd_meta;
    logic [ABS_BITS-1:0] rd_high;
    logic [CW-1:0]       sel_idx;
    always_comb begin
        rd_meta = '0;
        rd_high = '0;
        sel_idx = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (r_sel[i]) begin
                rd_meta = rd_meta | cell_meta[i];
                rd_high = rd_high | cell_high[i];
                sel_idx = sel_idx | CW'(i);
            end
        end
    end

    // Block length for the frame's codec, used when the slot opens.
    logic [BLEN_W-1:0] cfg_blen;
    always_comb begin
        case (r_codec)
            CODEC_OPUS:  cfg_blen = r_opus_blen;
            CODEC_PCM:   cfg_blen = r_pcm_blen;
            CODEC_SYNTH: cfg_blen = r_synth_blen;
            default:     cfg_blen = r_other_blen;
        endcase
    end

    // Unwrap against the slot's highest absolute id.
    logic                opened_eff;
    logic                first_now;
    logic [SEQ_BITS-1:0] fwd;
    logic                forward;
    logic [AW1-1:0]      fwd_sum;
    logic [SEQ_BITS:0]   back;
    logic [AW1-1:0]      back_diff;
    logic [ABS_BITS-1:0] raw_abs;
    logic [ABS_BITS-1:0] unwrapped;
    logic [ABS_BITS-1:0] abs_now;
    always_comb begin
        opened_eff = r_hit & r_old_meta.opened;
        first_now  = r_done & ~opened_eff;
        fwd        = r_raw - r_old_high[SEQ_BITS-1:0];
        forward    = ({1'b0, fwd} <= SEQ_HALF);
        fwd_sum    = {1'b0, r_old_high} + {{(AW1 - SEQ_BITS){1'b0}}, fwd};
        back       = SEQ_MOD - {1'b0, fwd};
        back_diff  = {1'b0, r_old_high} - {{(AW1 - SEQ_BITS - 1){1'b0}}, back};
        raw_abs    = {{(ABS_BITS - SEQ_BITS){1'b0}}, r_raw};
        if (forward) begin
            unwrapped = fwd_sum[ABS_BITS] ? ABS_MAX : fwd_sum[ABS_BITS-1:0];
        end else begin
            unwrapped = back_diff[ABS_BITS] ? '0 : back_diff[ABS_BITS-1:0];
        end
        abs_now = first_now ? raw_abs : unwrapped;

        wr_en          = (r_state == S_CALC) & ~r_full;
        wr_meta.opened = opened_eff | r_done;
        wr_meta.codec  = first_now ? r_codec : r_old_meta.codec;
        wr_meta.blen   = first_now ? r_new_blen : r_old_meta.blen;
        if (first_now) begin
            wr_high = raw_abs;
        end else if (r_done && forward) begin
            wr_high = unwrapped;
        end else begin
            wr_high = r_old_high;
        end
    end

    // Result fields: all zero for a dropped item, packet fields zero when no packet is timed.
    logic [TS_W-1:0]   ts_sat;
    logic              ts_over;
    logic [SLOT_W-1:0] slot_out;
    logic              res_emit;
    logic [OUT_DATA_W-1:0] n_m_data;
    always_comb begin
        ts_over = 1'b0;
        for (int b = TS_W; b < PW; b++) begin
            ts_over = ts_over | r_prod[b];
        end
        for (int b = 0; b < TS_W; b++) begin
            ts_sat[b] = ts_over | ((b < PW) ? r_prod[b] : 1'b0);
        end
        for (int b = 0; b < SLOT_W; b++) begin
            slot_out[b] = (b < CW) ? sel_idx[b] : 1'b0;
        end
        res_emit = ~r_full & r_done;
        n_m_data = '0;
        n_m_data[0]     = ~r_full;
        n_m_data[6:1]   = r_full ? '0 : slot_out;
        n_m_data[7]     = res_emit;
        n_m_data[8]     = res_emit & r_first;
        n_m_data[66:9]  = res_emit ? ts_sat : '0;
        n_m_data[78:67] = res_emit ? r_dur : '0;
        n_m_data[86:79] = res_emit ? r_scodec : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            // In the output state the register is refilled below instead.
            if (r_m_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_src   <= s_axis_tdata[15:0];
                        r_done  <= s_axis_tdata[16];
                        r_raw   <= n_raw;
                        r_codec <= s_axis_tdata[35:28];
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // Source ids are unique among used slots, so a hit is one-hot.
                    r_hit  <= |cell_hit;
                    r_sel  <= (|cell_hit) ? cell_hit : cell_grant;
                    r_full <= ~(|cell_hit) & ~cell_free_seen[NUM_SOURCES];
                    if (~(|cell_hit) & ~cell_free_seen[NUM_SOURCES]) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_old_meta <= rd_meta;
                    r_old_high <= rd_high;
                    r_new_blen <= cfg_blen;
                    r_state    <= S_CALC;
                end
                S_CALC: begin
                    r_first  <= first_now;
                    r_abs    <= abs_now;
                    r_dur    <= wr_meta.blen;
                    r_scodec <= wr_meta.codec;
                    r_state  <= r_done ? S_MUL : S_OUT;
                end
                S_MUL: begin
                    r_prod  <= {{BLEN_W{1'b0}}, r_abs} * {{ABS_BITS{1'b0}}, r_dur};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= n_m_data;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/psu_checker.sv */
// Port-level checker for the per-source sequence unwrapper, with its bind.
module psu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);

    // The output register comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // One item at a time: an accepted beat closes the input until its work is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    // A dropped item reports nothing else.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata == '0))
        else $error("dropped item with nonzero fields");

    // Without a timed packet the packet fields stay zero.
    a_no_emit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[7]) |-> (m_axis_tdata[87:8] == '0))
        else $error("packet fields set without a timed packet");

    // A held result keeps its data while the sink stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");

endmodule

bind per_source_sequence_unwrapper psu_checker u_psu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
